@@ design/vector_alu_with_matrix_transform_assert.svh @@
// ----------------------------------------------------------------------------
// Vector ALU assertion macros
// Shared property forms for the vector ALU checker.
// ----------------------------------------------------------------------------
`ifndef VECTOR_ALU_WITH_MATRIX_TRANSFORM_ASSERT_SVH
`define VECTOR_ALU_WITH_MATRIX_TRANSFORM_ASSERT_SVH

// same-cycle implication, disabled during reset
`define VAMT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define VAMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/vamt_pkg.sv @@
// ----------------------------------------------------------------------------
// Vector ALU package
// Item types, operation codes and per-lane operand bundle.
// ----------------------------------------------------------------------------
package vamt_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int N_ROWS     = 4;

    typedef enum logic [2:0] {
        FN_ADD   = 3'd0,
        FN_SUB   = 3'd1,
        FN_DOT   = 3'd2,
        FN_SCALE = 3'd3,
        FN_CROSS = 3'd4,
        FN_MAT   = 3'd5
    } t_func;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [15:0] a_x;
        logic signed [15:0] a_y;
        logic signed [15:0] a_z;
        logic signed [15:0] a_w;
        logic signed [15:0] b_x;
        logic signed [15:0] b_y;
        logic signed [15:0] b_z;
        logic signed [15:0] b_w;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] r_x;
        logic signed [15:0] r_y;
        logic signed [15:0] r_z;
        logic signed [15:0] r_w;
        logic               saturated;
    } t_out_item;

    // one result component: sum over four terms of +/- p*q
    typedef struct packed {
        logic [3:0]       neg;
        logic [3:0][15:0] p;
        logic [3:0][15:0] q;
    } t_lane_ops;

endpackage

@@ design/vamt_opsel.sv @@
// ----------------------------------------------------------------------------
// Vector ALU operand select
// Maps an operation onto four product-sum lanes.
// ----------------------------------------------------------------------------
module vamt_opsel #(
    parameter int FRAC_BITS = 8
) (
    input  vamt_pkg::t_in_item             i_item,
    input  logic [3:0][63:0]               i_rows,
    output vamt_pkg::t_lane_ops [3:0]      o_ops
);
    import vamt_pkg::*;

    localparam logic [15:0] ONE = 16'(1 << FRAC_BITS);

    logic [3:0][15:0] w_a;
    logic [3:0][15:0] w_b;

    assign w_a = {i_item.a_w, i_item.a_z, i_item.a_y, i_item.a_x};
    assign w_b = {i_item.b_w, i_item.b_z, i_item.b_y, i_item.b_x};

    always_comb begin
        o_ops = '0;
        unique case (t_func'(i_item.func))
            FN_ADD: begin
                for (int i = 0; i < 4; i++) begin
                    o_ops[i].p[0] = w_a[i];
                    o_ops[i].q[0] = ONE;
                    o_ops[i].p[1] = w_b[i];
                    o_ops[i].q[1] = ONE;
                end
            end
            FN_SUB: begin
                for (int i = 0; i < 4; i++) begin
                    o_ops[i].p[0]   = w_a[i];
                    o_ops[i].q[0]   = ONE;
                    o_ops[i].p[1]   = w_b[i];
                    o_ops[i].q[1]   = ONE;
                    o_ops[i].neg[1] = 1'b1;
                end
            end
            FN_DOT: begin
                for (int j = 0; j < 4; j++) begin
                    o_ops[0].p[j] = w_a[j];
                    o_ops[0].q[j] = w_b[j];
                end
            end
            FN_SCALE: begin
                for (int i = 0; i < 4; i++) begin
                    o_ops[i].p[0] = w_a[i];
                    o_ops[i].q[0] = w_b[0];
                end
            end
            FN_CROSS: begin
                o_ops[0].p[0]   = w_a[1];
                o_ops[0].q[0]   = w_b[2];
                o_ops[0].p[1]   = w_a[2];
                o_ops[0].q[1]   = w_b[1];
                o_ops[0].neg[1] = 1'b1;
                o_ops[1].p[0]   = w_a[2];
                o_ops[1].q[0]   = w_b[0];
                o_ops[1].p[1]   = w_a[0];
                o_ops[1].q[1]   = w_b[2];
                o_ops[1].neg[1] = 1'b1;
                o_ops[2].p[0]   = w_a[0];
                o_ops[2].q[0]   = w_b[1];
                o_ops[2].p[1]   = w_a[1];
                o_ops[2].q[1]   = w_b[0];
                o_ops[2].neg[1] = 1'b1;
            end
            FN_MAT: begin
                for (int i = 0; i < 4; i++) begin
                    for (int j = 0; j < 4; j++) begin
                        o_ops[i].p[j] = i_rows[i][16*j +: 16];
                        o_ops[i].q[j] = w_a[j];
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

@@ design/vamt_lane.sv @@
// ----------------------------------------------------------------------------
// Vector ALU lane
// Four signed products summed, rounded, rescaled and clamped to 16 bits.
// ----------------------------------------------------------------------------
module vamt_lane #(
    parameter int FRAC_BITS = 8
) (
    input  vamt_pkg::t_lane_ops i_ops,
    output logic signed [15:0]  o_res,
    output logic                o_sat
);
    import vamt_pkg::*;

    localparam int SUM_W = 35;
    localparam logic signed [SUM_W-1:0] BIAS  = SUM_W'((1 << FRAC_BITS) >> 1);
    localparam logic signed [SUM_W-1:0] MAX_V = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] MIN_V = SUM_W'(-32768);

    logic signed [31:0]      w_prod [4];
    logic signed [SUM_W-1:0] w_term [4];
    logic signed [SUM_W-1:0] w_sum;
    logic signed [SUM_W-1:0] w_scaled;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            w_prod[j] = $signed(i_ops.p[j]) * $signed(i_ops.q[j]);
            w_term[j] = i_ops.neg[j] ? -SUM_W'(w_prod[j]) : SUM_W'(w_prod[j]);
        end
        w_sum    = w_term[0] + w_term[1] + w_term[2] + w_term[3] + BIAS;
        w_scaled = w_sum >>> FRAC_BITS;
    end

    always_comb begin
        priority if (w_scaled > MAX_V) begin
            o_res = 16'sh7fff;
            o_sat = 1'b1;
        end else if (w_scaled < MIN_V) begin
            o_res = 16'sh8000;
            o_sat = 1'b1;
        end else begin
            o_res = w_scaled[15:0];
            o_sat = 1'b0;
        end
    end

endmodule

@@ design/vector_alu_with_matrix_transform.sv @@
// ----------------------------------------------------------------------------
// Vector ALU with 4x4 matrix transform
// Accepts one item per clock cycle unless both registers are full and the
// output side stalls; each item passes through the input register and the
// result register, which sit around four lanes of four 16x16 multipliers with
// a rounding adder and clamp. Back-pressure from the output stalls the input
// register only once the result register is full.
// The matrix rows are written through the configuration port and reset to
// identity; write them only while no item is in flight.
// ----------------------------------------------------------------------------
module vector_alu_with_matrix_transform #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  vamt_pkg::t_in_item                   i_item,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output vamt_pkg::t_out_item                  o_item,
    input  logic                                 i_cfg_we,
    input  logic [vamt_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [vamt_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import vamt_pkg::*;

    localparam logic [15:0] ONE = 16'(1 << FRAC_BITS);

    logic [N_ROWS-1:0][CFG_DATA_W-1:0] r_rows;
    logic                              r_in_vld;
    t_in_item                          r_in;
    logic                              r_out_vld;
    t_out_item                         r_out;
    t_out_item                         n_out;

    logic                              w_out_en;
    t_lane_ops [3:0]                   w_ops;
    logic [3:0][15:0]                  w_res;
    logic [3:0]                        w_sat;

    assign w_out_en = !r_out_vld || i_ready;
    assign o_ready  = !r_in_vld || w_out_en;
    assign o_valid  = r_out_vld;
    assign o_item   = r_out;

    vamt_opsel #(
        .FRAC_BITS (FRAC_BITS)
    ) u_opsel (
        .i_item (r_in),
        .i_rows (r_rows),
        .o_ops  (w_ops)
    );

    for (genvar g = 0; g < 4; g++) begin : g_lane
        vamt_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_ops (w_ops[g]),
            .o_res (w_res[g]),
            .o_sat (w_sat[g])
        );
    end

    always_comb begin
        n_out.r_x       = w_res[0];
        n_out.r_y       = w_res[1];
        n_out.r_z       = w_res[2];
        n_out.r_w       = w_res[3];
        n_out.saturated = |w_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < N_ROWS; i++) begin
                r_rows[i] <= CFG_DATA_W'(ONE) << (16 * i);
            end
        end else begin
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (w_out_en) begin
                r_out_vld <= r_in_vld;
            end
            if (i_cfg_we) begin
                r_rows[i_cfg_idx] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_item;
        end
        if (w_out_en && r_in_vld) begin
            r_out <= n_out;
        end
    end

endmodule

@@ design/vamt_checker.sv @@
// ----------------------------------------------------------------------------
// Vector ALU port checker
// Watches the item handshakes and result flags of the vector ALU.
// ----------------------------------------------------------------------------
`include "vector_alu_with_matrix_transform_assert.svh"

module vamt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input vamt_pkg::t_out_item o_item
);
    import vamt_pkg::*;

    `VAMT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_item), "result item changed while stalled")

    `VAMT_ASSERT_IMPLY(a_ready_when_empty, i_clk, i_rst_n, !o_valid, o_ready, "input stalled with empty output")

    `VAMT_ASSERT_IMPLY(a_rise_from_accept, i_clk, i_rst_n, $rose(o_valid), $past(i_valid && o_ready, 2), "result item without accepted item")

    `VAMT_ASSERT_IMPLY(a_sat_at_rail, i_clk, i_rst_n, o_valid && o_item.saturated, o_item.r_x == 16'h7fff || o_item.r_x == 16'h8000 || o_item.r_y == 16'h7fff || o_item.r_y == 16'h8000 || o_item.r_z == 16'h7fff || o_item.r_z == 16'h8000 || o_item.r_w == 16'h7fff || o_item.r_w == 16'h8000, "saturated flag without clamped component")

endmodule

bind vector_alu_with_matrix_transform vamt_checker u_vamt_checker (.*);

@@ verif/vector_alu_with_matrix_transform_checker.sv @@
// ----------------------------------------------------------------------------
// Vector ALU checker
// Watches the item, result and matrix write ports of the vector ALU. For
// every accepted item it computes the expected result from its own copy of
// the matrix rows, then compares each delivered result field by field
// against the oldest expectation. Reports the mismatch count, the number of
// results still outstanding and the number compared.
// ----------------------------------------------------------------------------
module vector_alu_with_matrix_transform_checker #(
    parameter int FRAC_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  vamt_pkg::t_in_item               i_in_item,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  vamt_pkg::t_out_item              i_out_item,
    input  logic                             i_cfg_we,
    input  logic [vamt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [vamt_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                               o_err_cnt,
    output int                               o_pending,
    output int                               o_checked
);
    import vamt_pkg::*;

    localparam int          MAX_REPORTS = 100;
    localparam logic [63:0] UNIT_COEF   = 64'(1) << FRAC_BITS;
    localparam longint      HALF_LSB    =
        (FRAC_BITS == 0) ? 0 : (longint'(1) << (FRAC_BITS - 1));

    logic [CFG_DATA_W-1:0] matrix_rows [N_ROWS];
    t_out_item             expected_results [$];
    t_out_item             expected;
    int                    mismatch_cnt = 0;
    int                    compared_cnt = 0;

    assign o_err_cnt = mismatch_cnt;
    assign o_checked = compared_cnt;

    function automatic longint round_shift(longint s);
        return (s + HALF_LSB) >>> FRAC_BITS;
    endfunction

    function automatic logic [15:0] clamp_to_16(longint v, inout logic sat);
        if (v > 32767) begin
            sat = 1'b1;
            return 16'h7FFF;
        end
        if (v < -32768) begin
            sat = 1'b1;
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    function automatic t_out_item predict_result(t_in_item it);
        longint    a [4];
        longint    b [4];
        longint    acc [4];
        longint    sum;
        logic      sat;
        t_out_item res;
        a[0] = longint'($signed(it.a_x));
        a[1] = longint'($signed(it.a_y));
        a[2] = longint'($signed(it.a_z));
        a[3] = longint'($signed(it.a_w));
        b[0] = longint'($signed(it.b_x));
        b[1] = longint'($signed(it.b_y));
        b[2] = longint'($signed(it.b_z));
        b[3] = longint'($signed(it.b_w));
        for (int i = 0; i < 4; i++) acc[i] = 0;
        sat = 1'b0;
        case (it.func)
            FN_ADD: begin
                for (int i = 0; i < 4; i++) acc[i] = a[i] + b[i];
            end
            FN_SUB: begin
                for (int i = 0; i < 4; i++) acc[i] = a[i] - b[i];
            end
            FN_DOT: begin
                acc[0] = round_shift(a[0] * b[0] + a[1] * b[1] +
                                     a[2] * b[2] + a[3] * b[3]);
            end
            FN_SCALE: begin
                for (int i = 0; i < 4; i++) acc[i] = round_shift(b[0] * a[i]);
            end
            FN_CROSS: begin
                acc[0] = round_shift(a[1] * b[2] - a[2] * b[1]);
                acc[1] = round_shift(a[2] * b[0] - a[0] * b[2]);
                acc[2] = round_shift(a[0] * b[1] - a[1] * b[0]);
            end
            FN_MAT: begin
                for (int i = 0; i < N_ROWS; i++) begin
                    sum = 0;
                    for (int j = 0; j < 4; j++)
                        sum += longint'($signed(matrix_rows[i][16*j +: 16])) * a[j];
                    acc[i] = round_shift(sum);
                end
            end
            default: ;
        endcase
        res.r_x       = clamp_to_16(acc[0], sat);
        res.r_y       = clamp_to_16(acc[1], sat);
        res.r_z       = clamp_to_16(acc[2], sat);
        res.r_w       = clamp_to_16(acc[3], sat);
        res.saturated = sat;
        return res;
    endfunction

    task automatic check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
        if (exp_val !== act_val) begin
            if (mismatch_cnt < MAX_REPORTS)
                $display("%0t: %s mismatch: expected %h, actual %h",
                         $time, name, exp_val, act_val);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_results.delete();
            for (int i = 0; i < N_ROWS; i++) matrix_rows[i] = UNIT_COEF << (16 * i);
            o_pending <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    if (mismatch_cnt < MAX_REPORTS)
                        $display("%0t: result with no item outstanding: expected none, actual %h",
                                 $time, i_out_item);
                    mismatch_cnt++;
                end else begin
                    expected = expected_results.pop_front();
                    check_field("r_x", expected.r_x, i_out_item.r_x);
                    check_field("r_y", expected.r_y, i_out_item.r_y);
                    check_field("r_z", expected.r_z, i_out_item.r_z);
                    check_field("r_w", expected.r_w, i_out_item.r_w);
                    check_field("saturated", {15'd0, expected.saturated},
                                {15'd0, i_out_item.saturated});
                    compared_cnt++;
                end
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(predict_result(i_in_item));
            if (i_cfg_we)
                matrix_rows[i_cfg_idx] = i_cfg_data;
            o_pending <= expected_results.size();
        end
    end

endmodule

@@ verif/vector_alu_with_matrix_transform_tb.sv @@
// ----------------------------------------------------------------------------
// Vector ALU testbench
// Drives the vector ALU with a directed set of corner items followed by
// random items under six matrix settings, with random gaps on the item side
// and random stalls on the result side in three patterns. A separate checker
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module vector_alu_with_matrix_transform_tb;
    import vamt_pkg::*;

    localparam int          FRAC_BITS    = 8;
    localparam int          N_PHASES     = 6;
    localparam int          PHASE_ITEMS  = 200;
    localparam int          DRAIN_CYCLES = 4;
    localparam int          STALL_LIMIT  = 1000;
    localparam logic [2:0]  FN_RSVD6     = 3'd6;
    localparam logic [2:0]  FN_RSVD7     = 3'd7;
    localparam logic [1:0]  REG_ROW0     = 2'd0;
    localparam logic [1:0]  REG_ROW1     = 2'd1;
    localparam logic [1:0]  REG_ROW2     = 2'd2;
    localparam logic [1:0]  REG_ROW3     = 2'd3;
    localparam logic [63:0] ROW_ALL_MAX  = 64'h7FFF_7FFF_7FFF_7FFF;
    localparam logic [63:0] ROW_ALL_MIN  = 64'h8000_8000_8000_8000;
    localparam logic [63:0] ROW_ZERO     = 64'h0;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_valid    = 1'b0;
    logic                  o_ready;
    t_in_item              i_item     = '0;
    logic                  o_valid;
    logic                  i_ready    = 1'b0;
    t_out_item             o_item;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int err_cnt;
    int pending_cnt;
    int checked_cnt;
    int items_sent     = 0;
    int idle_cycles    = 0;
    int send_gap_pct   = 18;
    int recv_stall_pct = 46;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    vector_alu_with_matrix_transform #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (i_item),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_item    (o_item),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    vector_alu_with_matrix_transform_checker #(
        .FRAC_BITS(FRAC_BITS)
    ) u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_in_ready (o_ready),
        .i_in_item  (i_item),
        .i_out_valid(o_valid),
        .i_out_ready(i_ready),
        .i_out_item (o_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_err_cnt  (err_cnt),
        .o_pending  (pending_cnt),
        .o_checked  (checked_cnt)
    );

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [15:0] rand_operand();
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2, 3: return 16'($urandom_range(1023)) - 16'd512;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        if ($urandom_range(99) < 4)
            it.func = $urandom_range(1) ? FN_RSVD7 : FN_RSVD6;
        else
            it.func = 3'($urandom_range(5));
        it.a_x = rand_operand();
        it.a_y = rand_operand();
        it.a_z = rand_operand();
        it.a_w = rand_operand();
        it.b_x = rand_operand();
        it.b_y = rand_operand();
        it.b_z = rand_operand();
        it.b_w = rand_operand();
        return it;
    endfunction

    function automatic logic [63:0] rand_small_row();
        logic [63:0] row;
        for (int j = 0; j < 4; j++) row[16*j +: 16] = 16'($urandom_range(1023)) - 16'd512;
        return row;
    endfunction

    // hold valid and payload until the item is taken
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
    endtask

    task automatic send_vec(input logic [2:0] fn,
                            input logic [15:0] ax, ay, az, aw, bx, by, bz, bw);
        t_in_item it;
        it.func = fn;
        it.a_x = ax; it.a_y = ay; it.a_z = az; it.a_w = aw;
        it.b_x = bx; it.b_y = by; it.b_z = bz; it.b_w = bw;
        send_item(it);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic load_matrix(input logic [63:0] r0, r1, r2, r3);
        wait_drained();
        write_reg(REG_ROW0, r0);
        write_reg(REG_ROW1, r1);
        write_reg(REG_ROW2, r2);
        write_reg(REG_ROW3, r3);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_corner_items();
        send_vec(FN_ADD,   16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                           16'h0001, 16'h0001, 16'h0001, 16'h0001);
        send_vec(FN_ADD,   16'h8000, 16'h8000, 16'h8000, 16'h8000,
                           16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_vec(FN_ADD,   16'h0000, 16'h0000, 16'h0000, 16'h0000,
                           16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_vec(FN_SUB,   16'h8000, 16'h0100, 16'h0080, 16'h0100,
                           16'h0001, 16'h0200, 16'hFF80, 16'h0300);
        send_vec(FN_SUB,   16'h7FFF, 16'h7FFF, 16'h0000, 16'h8000,
                           16'h8000, 16'hFFFF, 16'h8000, 16'h0001);
        send_vec(FN_DOT,   16'h0001, 16'h0000, 16'h0000, 16'h0000,
                           16'h0080, 16'h0000, 16'h0000, 16'h0000);
        send_vec(FN_DOT,   16'hFFFF, 16'h0000, 16'h0000, 16'h0001,
                           16'h0080, 16'h0000, 16'h0000, 16'hFF7F);
        send_vec(FN_DOT,   16'h8000, 16'h8000, 16'h8000, 16'h8000,
                           16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_vec(FN_DOT,   16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                           16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_vec(FN_DOT,   16'h0100, 16'h0200, 16'h0300, 16'h0400,
                           16'h0100, 16'hFF00, 16'h0080, 16'h0040);
        send_vec(FN_SCALE, 16'h0100, 16'h0200, 16'hFF00, 16'h0080,
                           16'h0180, 16'h1234, 16'h5678, 16'h9ABC);
        send_vec(FN_SCALE, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF,
                           16'h8000, 16'h0000, 16'h0000, 16'h0000);
        send_vec(FN_CROSS, 16'h0100, 16'h0000, 16'h0000, 16'h0400,
                           16'h0000, 16'h0100, 16'h0000, 16'h0500);
        send_vec(FN_CROSS, 16'h0200, 16'h0300, 16'h0400, 16'h7FFF,
                           16'h0500, 16'h0600, 16'h0700, 16'h8000);
        send_vec(FN_CROSS, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000,
                           16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000);
        send_vec(FN_MAT,   16'h7FFF, 16'h8000, 16'h1234, 16'hFFFF,
                           16'h0100, 16'h0100, 16'h0100, 16'h0100);
        send_vec(FN_MAT,   16'h0000, 16'h0000, 16'h0000, 16'h0000,
                           16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_vec(FN_RSVD6, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                           16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_vec(FN_RSVD7, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0,
                           16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int phase = 0; phase < N_PHASES; phase++) begin
            case (phase / 2)
                0: begin
                    send_gap_pct   = 18;
                    recv_stall_pct = 46;
                end
                1: begin
                    send_gap_pct   = 46;
                    recv_stall_pct = 18;
                end
                default: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            case (phase)
                0: send_corner_items();
                1: load_matrix(ROW_ALL_MAX, ROW_ALL_MAX, ROW_ALL_MAX, ROW_ALL_MAX);
                2: load_matrix(ROW_ALL_MIN, ROW_ALL_MIN, ROW_ALL_MIN, ROW_ALL_MIN);
                3: load_matrix({$urandom, $urandom}, {$urandom, $urandom},
                               {$urandom, $urandom}, {$urandom, $urandom});
                4: load_matrix(ROW_ZERO, ROW_ZERO, ROW_ZERO, ROW_ZERO);
                default: load_matrix(rand_small_row(), rand_small_row(),
                                     rand_small_row(), rand_small_row());
            endcase
            repeat (PHASE_ITEMS) send_item(rand_item());
        end

        wait_drained();
        $display("Sent %0d items under identity and five loaded matrices, three idling patterns.",
                 items_sent);
        $display("Compared %0d results field by field; %0d mismatches.", checked_cnt, err_cnt);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/vamt_pkg.sv
design/vamt_opsel.sv
design/vamt_lane.sv
design/vector_alu_with_matrix_transform.sv
design/vamt_checker.sv
verif/vector_alu_with_matrix_transform_checker.sv
verif/vector_alu_with_matrix_transform_tb.sv
